// ===== hdl/software_timer_bank_top_defines.svh =====
// assertion helpers shared by the timer bank rtl
`ifndef SOFTWARE_TIMER_BANK_TOP_DEFINES_SVH
`define SOFTWARE_TIMER_BANK_TOP_DEFINES_SVH

// checked on every edge out of reset
`define STB_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define STB_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/stb_pkg.sv =====
package stb_pkg;

    localparam int SLOTS = 16;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_ZERO  = CNT_W'(0);
    localparam logic [CNT_W-1:0] CNT_SLOTS = CNT_W'(SLOTS);

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_REMOVED   = 3'd2;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [2:0] KIND_FIRED     = 3'd4;
    localparam logic [2:0] KIND_DONE      = 3'd5;

    typedef struct packed {
        logic        valid;
        logic [30:0] ident;
        logic [30:0] delay;
        logic [31:0] start;
        logic        periodic;
    } entry_t;

    // shift_down: take the newer neighbor; shift_up: take the older one,
    // push: the last valid cell after the shift takes the recycled entry
    typedef struct packed {
        logic shift_down;
        logic shift_up;
        logic push;
    } chain_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_REMOVE = 4'b0010,
        ST_TICK   = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

endpackage

// ===== hdl/stb_cell.sv =====
module stb_cell
    import stb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  chain_ctl_t ctl,
    input  entry_t     newer,
    input  entry_t     older,
    input  entry_t     push_entry,
    output entry_t     cur
);

    logic   valid_reg, valid_next;
    entry_t data_reg, data_next;

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctl.shift_down) begin
            data_next  = newer;
            valid_next = newer.valid;
        end else if (ctl.shift_up) begin
            if (older.valid) begin
                data_next  = older;
                valid_next = 1'b1;
            end else if (ctl.push && valid_reg) begin
                data_next  = push_entry;
                valid_next = 1'b1;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    always_comb begin
        cur       = data_reg;
        cur.valid = valid_reg;
    end

endmodule

// ===== hdl/stb_chain.sv =====
module stb_chain
    import stb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  chain_ctl_t ctl,
    input  entry_t     add_entry,
    input  entry_t     push_entry,
    output entry_t     head,
    output logic       full
);

    entry_t cell_q [SLOTS];
    entry_t tail_fill;

    assign tail_fill = '0;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        entry_t newer_in;
        entry_t older_in;

        if (i == 0) begin : g_first
            assign newer_in = add_entry;
        end else begin : g_mid
            assign newer_in = cell_q[i-1];
        end

        if (i == SLOTS - 1) begin : g_last
            assign older_in = tail_fill;
        end else begin : g_inner
            assign older_in = cell_q[i+1];
        end

        stb_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .newer      (newer_in),
            .older      (older_in),
            .push_entry (push_entry),
            .cur        (cell_q[i])
        );
    end

    assign head = cell_q[0];
    assign full = cell_q[SLOTS-1].valid;

endmodule

// ===== hdl/software_timer_bank_top.sv =====
// software timer bank: up to SLOTS one-shot or periodic timers kept in a
// row of cells, newest timer in the first cell
// input channel s_*: one beat per command; tuser carries the command
// (add, remove, tick), tdata the time, delay, repeat flag and target id
// output channel m_*: result beats with kind on tuser, id on tdata and
// tlast on the final beat of a command
// add: one result, registered in the cycle after the beat is taken
// remove: the row rotates once through all n stored timers, one cell
// step per cycle; the result comes with the last step, or from the command if empty
// tick: same rotation, held while a result waits, then the done beat; each expired
// timer gives a fired beat, one-shots are dropped, periodic ones restart
// the time a command occupies the block is set by the number of stored timers
// walked through the head cell and by receiver stalls; unused command code 3
// is taken and ignored
// reset clears every cell's valid bit, the id counter and the output
// a stalled receiver holds the result register and freezes the walk;
// s_tready stays low until the command in flight has been handed off
module software_timer_bank_top
    import stb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,  // now_ms[31:0], delay_ms[62:32], periodic[63],
                                   // target_id[94:64], zero pad[95]
    input  logic [1:0]   s_tuser,  // func[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,  // timer_ident[30:0], zero pad[31]
    output logic [2:0]   m_tuser,  // kind[2:0]
    output logic         m_tlast
);

`include "software_timer_bank_top_defines.svh"

    // input fields
    logic [31:0] in_now;
    logic [30:0] in_delay;
    logic        in_periodic;
    logic [30:0] in_target;

    assign in_now      = s_tdata[31:0];
    assign in_delay    = s_tdata[62:32];
    assign in_periodic = s_tdata[63];
    assign in_target   = s_tdata[94:64];

    // control state
    state_t           st_reg, st_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;      // stored timers
    logic [CNT_W-1:0] step_reg, step_next;    // head steps left in the walk
    logic             found_reg, found_next;
    logic [30:0]      id_reg, id_next;
    logic [31:0]      now_reg, now_next;
    logic [30:0]      target_reg, target_next;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic [2:0]  m_kind_reg, m_kind_next;
    logic [30:0] m_ident_reg, m_ident_next;
    logic        m_last_reg, m_last_next;

    // chain interface
    chain_ctl_t ctl;
    entry_t     add_entry;
    entry_t     push_entry;
    entry_t     head;
    logic       full;

    logic        out_free;
    logic        in_fire;
    logic [31:0] elapsed;
    logic        fire;
    logic        match;
    logic [30:0] id_inc;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (st_reg == ST_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;

    // wrapping elapsed time of the head timer
    assign elapsed = now_reg - head.start;
    assign fire    = elapsed >= {1'b0, head.delay};
    assign match   = !found_reg && (head.ident == target_reg);
    assign id_inc  = id_reg + 31'd1;

    always_comb begin
        add_entry          = '0;
        add_entry.valid    = 1'b1;
        add_entry.ident    = id_inc;
        add_entry.delay    = in_delay;
        add_entry.start    = in_now;
        add_entry.periodic = in_periodic;
    end

    // head goes back to the tail; a fired periodic timer restarts now
    always_comb begin
        push_entry = head;
        if (st_reg == ST_TICK && fire) begin
            push_entry.start = now_reg;
        end
    end

    always_comb begin
        st_next      = st_reg;
        cnt_next     = cnt_reg;
        step_next    = step_reg;
        found_next   = found_reg;
        id_next      = id_reg;
        now_next     = now_reg;
        target_next  = target_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_kind_next  = m_kind_reg;
        m_ident_next = m_ident_reg;
        m_last_next  = m_last_reg;
        ctl          = '0;

        case (st_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    now_next    = in_now;
                    target_next = in_target;
                    case (s_tuser)
                        FUNC_ADD: begin
                            m_valid_next = 1'b1;
                            m_last_next  = 1'b1;
                            if (full) begin
                                m_kind_next  = KIND_FULL;
                                m_ident_next = '0;
                            end else begin
                                ctl.shift_down = 1'b1;
                                id_next        = id_inc;
                                cnt_next       = cnt_reg + CNT_ONE;
                                m_kind_next    = KIND_ADDED;
                                m_ident_next   = id_inc;
                            end
                        end
                        FUNC_REMOVE: begin
                            if (cnt_reg == CNT_ZERO) begin
                                m_valid_next = 1'b1;
                                m_last_next  = 1'b1;
                                m_kind_next  = KIND_NOT_FOUND;
                                m_ident_next = '0;
                            end else begin
                                step_next  = cnt_reg;
                                found_next = 1'b0;
                                st_next    = ST_REMOVE;
                            end
                        end
                        FUNC_TICK: begin
                            if (cnt_reg == CNT_ZERO) begin
                                m_valid_next = 1'b1;
                                m_last_next  = 1'b1;
                                m_kind_next  = KIND_DONE;
                                m_ident_next = '0;
                            end else begin
                                step_next = cnt_reg;
                                st_next   = ST_TICK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_REMOVE: begin
                // output register is empty for the whole walk
                ctl.shift_up = 1'b1;
                if (match) begin
                    found_next = 1'b1;
                    cnt_next   = cnt_reg - CNT_ONE;
                end else begin
                    ctl.push = 1'b1;
                end
                step_next = step_reg - CNT_ONE;
                if (step_reg == CNT_ONE) begin
                    st_next      = ST_IDLE;
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    if (found_reg || match) begin
                        m_kind_next  = KIND_REMOVED;
                        m_ident_next = target_reg;
                    end else begin
                        m_kind_next  = KIND_NOT_FOUND;
                        m_ident_next = '0;
                    end
                end
            end
            ST_TICK: begin
                if (out_free) begin
                    ctl.shift_up = 1'b1;
                    if (fire) begin
                        m_valid_next = 1'b1;
                        m_last_next  = 1'b0;
                        m_kind_next  = KIND_FIRED;
                        m_ident_next = head.ident;
                        if (head.periodic) begin
                            ctl.push = 1'b1;
                        end else begin
                            cnt_next = cnt_reg - CNT_ONE;
                        end
                    end else begin
                        ctl.push = 1'b1;
                    end
                    step_next = step_reg - CNT_ONE;
                    if (step_reg == CNT_ONE) begin
                        st_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    m_kind_next  = KIND_DONE;
                    m_ident_next = '0;
                    st_next      = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            cnt_reg     <= CNT_ZERO;
            step_reg    <= CNT_ZERO;
            found_reg   <= 1'b0;
            id_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            cnt_reg     <= cnt_next;
            step_reg    <= step_next;
            found_reg   <= found_next;
            id_reg      <= id_next;
            m_valid_reg <= m_valid_next;
        end
        now_reg     <= now_next;
        target_reg  <= target_next;
        m_kind_reg  <= m_kind_next;
        m_ident_reg <= m_ident_next;
        m_last_reg  <= m_last_next;
    end

    stb_chain u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .add_entry  (add_entry),
        .push_entry (push_entry),
        .head       (head),
        .full       (full)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_ident_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    // timer count never exceeds the row
    `STB_CHECK(a_cnt_range, cnt_reg <= CNT_SLOTS, "timer count above slot count")
    // the count and the last cell agree on a full bank
    `STB_CHECK(a_full_cnt, full == (cnt_reg == CNT_SLOTS), "full flag disagrees with count")
    // a walk always has a stored timer at the head
    `STB_CHECK(a_head_valid, (st_reg == ST_REMOVE || st_reg == ST_TICK) |-> head.valid,
        "walk step without a timer at the head")
    // a remove never overlaps a pending result
    `STB_CHECK(a_remove_quiet, st_reg == ST_REMOVE |-> !m_valid_reg,
        "result pending during a remove walk")
    // a running walk always has at least one head step left
    `STB_CHECK(a_step_nonzero, (st_reg == ST_REMOVE || st_reg == ST_TICK) |-> step_reg != CNT_ZERO,
        "walk running with no steps left")

endmodule

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stb_pkg::*;

    // command code 3 is accepted by the block and dropped
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int GAP_MAX      = 13;
    localparam int RANDOM_ITEMS = 125;
    localparam int CYCLE_LIMIT  = 400_000;
    // one full walk of the row plus the done beat, with margin
    localparam int SETTLE_CYCLES = 2 * SLOTS + 8;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] now_ms;
        logic [30:0] delay_ms;
        logic        periodic;
        logic [30:0] target_id;
    } command_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [30:0] ident;
        logic        last;
    } timer_event_t;

    // typed: the expected beat is written into the row, otherwise it
    // comes from the timer bank shadow
    typedef struct {
        command_t     cmd;
        bit           typed;
        timer_event_t want;
    } stim_row_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // input channel, all known from time zero
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;

    // result channel
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    software_timer_bank_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // shadow copy of the timer row, newest timer at index 0
    entry_t       timer_row [SLOTS];
    logic [30:0]  issued_id = '0;
    timer_event_t step_events[$];
    // expected beats, oldest first
    timer_event_t pending_events[$];
    stim_row_t    directed_rows[$];

    int          error_count  = 0;
    int          cycle_count  = 0;
    logic [31:0] wall_ms      = 32'hFFFF_FC00;  // wraps early in the random part
    bit          sender_quiet = 1'b0;
    bit          sink_quiet   = 1'b0;

    initial begin
        foreach (timer_row[i]) timer_row[i] = '0;
    end

    // timers in use; valid entries are packed from index 0
    function automatic int live_timers();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (timer_row[i].valid) n = i + 1;
        return n;
    endfunction

    // drop the entry at idx, older entries move up one place
    function automatic void drop_timer(int idx);
        for (int j = idx; j < SLOTS - 1; j++) timer_row[j] = timer_row[j + 1];
        timer_row[SLOTS - 1] = '0;
    endfunction

    // apply one command to the shadow and collect the beats it causes
    function automatic void advance_bank(command_t c);
        int          n;
        int          i;
        bit          hit;
        logic [31:0] elapsed;
        n = live_timers();
        hit = 1'b0;
        step_events.delete();
        case (c.func)
            FUNC_ADD: begin
                if (n >= SLOTS) begin
                    step_events.push_back('{KIND_FULL, 31'd0, 1'b1});
                end else begin
                    for (i = SLOTS - 1; i > 0; i--) timer_row[i] = timer_row[i - 1];
                    issued_id = issued_id + 31'd1;
                    timer_row[0] = '{1'b1, issued_id, c.delay_ms, c.now_ms, c.periodic};
                    step_events.push_back('{KIND_ADDED, issued_id, 1'b1});
                end
            end
            FUNC_REMOVE: begin
                for (i = 0; i < SLOTS && !hit; i++) begin
                    if (timer_row[i].valid && timer_row[i].ident == c.target_id) begin
                        drop_timer(i);
                        hit = 1'b1;
                    end
                end
                if (hit) step_events.push_back('{KIND_REMOVED, c.target_id, 1'b1});
                else step_events.push_back('{KIND_NOT_FOUND, 31'd0, 1'b1});
            end
            FUNC_TICK: begin
                i = 0;
                while (i < SLOTS && timer_row[i].valid) begin
                    elapsed = c.now_ms - timer_row[i].start;
                    if (elapsed >= {1'b0, timer_row[i].delay}) begin
                        step_events.push_back('{KIND_FIRED, timer_row[i].ident, 1'b0});
                        if (timer_row[i].periodic) begin
                            timer_row[i].start = c.now_ms;
                            i++;
                        end else begin
                            drop_timer(i);
                        end
                    end else begin
                        i++;
                    end
                end
                step_events.push_back('{KIND_DONE, 31'd0, 1'b1});
            end
            default: ;
        endcase
    endfunction

    function automatic void add_row(logic [1:0] func, logic [31:0] now_ms,
                                    logic [30:0] delay_ms, logic periodic,
                                    logic [30:0] target_id, bit typed,
                                    logic [2:0] kind, logic [30:0] ident);
        stim_row_t row;
        row.cmd   = '{func, now_ms, delay_ms, periodic, target_id};
        row.typed = typed;
        row.want  = '{kind, ident, 1'b1};
        directed_rows.push_back(row);
    endfunction

    // random command; fill phases lean on adds so the bank runs full
    function automatic command_t random_command(bit fill_phase);
        command_t c;
        int       roll;
        int       n;
        n = live_timers();
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 11) == 0) wall_ms = $urandom;
        else wall_ms = wall_ms + 32'($urandom_range(0, 150));
        c.now_ms    = wall_ms;
        c.delay_ms  = ($urandom_range(0, 9) < 7) ? 31'($urandom_range(0, 300))
                                                  : 31'($urandom);
        c.periodic  = 1'($urandom_range(0, 1));
        c.target_id = 31'($urandom);
        if (roll < (fill_phase ? 65 : 30)) begin
            c.func = FUNC_ADD;
        end else if (roll < (fill_phase ? 80 : 50)) begin
            c.func = FUNC_REMOVE;
            // mostly a live id, sometimes a stray one
            if (n > 0 && $urandom_range(0, 4) != 0)
                c.target_id = timer_row[$urandom_range(0, n - 1)].ident;
        end else if (roll < 96) begin
            c.func = FUNC_TICK;
        end else begin
            c.func = FUNC_UNUSED;
        end
        return c;
    endfunction

    // one input beat: random gap, present, wait for the handshake, predict
    task automatic drive_command(command_t c, bit typed, timer_event_t want);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, GAP_MAX);
        if ($urandom_range(0, 19) == 0) sender_quiet = !sender_quiet;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.func;
        s_tdata  <= {1'b0, c.target_id, c.periodic, c.delay_ms, c.now_ms};
        do @(posedge aclk); while (!s_tready);
        advance_bank(c);
        if (typed) pending_events.push_back(want);
        else foreach (step_events[k]) pending_events.push_back(step_events[k]);
    endtask

    // hold the sender until every expected beat has been seen
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_events.size() != 0);
    endtask

    // receiver: random stall before each beat, quiet stretches in between
    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            stall = sink_quiet ? 0 : $urandom_range(0, GAP_MAX);
            if ($urandom_range(0, 19) == 0) sink_quiet = !sink_quiet;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // result checker, oldest expectation first
    always @(posedge aclk) begin
        timer_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got kind %0d ident %0d last %0b",
                         $time, m_tuser, m_tdata, m_tlast);
                error_count++;
            end else begin
                want = pending_events.pop_front();
                if (m_tuser !== want.kind) begin
                    $display("%0t: kind mismatch, expected %0d, got %0d",
                             $time, want.kind, m_tuser);
                    error_count++;
                end
                if (m_tdata !== {1'b0, want.ident}) begin
                    $display("%0t: timer_ident mismatch, expected %0d, got %0d",
                             $time, want.ident, m_tdata);
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last mismatch, expected %0b, got %0b",
                             $time, want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        command_t c;
        int       done_items;

        // empty bank: tick still closes, remove misses, code 3 is dropped
        add_row(FUNC_TICK, 32'd0, 31'd0, 1'b0, 31'd0, 1'b1, KIND_DONE, 31'd0);
        add_row(FUNC_REMOVE, 32'd0, 31'd0, 1'b0, 31'h7FFF_FFFF, 1'b1, KIND_NOT_FOUND, 31'd0);
        add_row(FUNC_UNUSED, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 31'h7FFF_FFFF, 1'b0,
                KIND_DONE, 31'd0);
        // zero delay one-shot, then maximum delay periodic started at the top of time
        add_row(FUNC_ADD, 32'd0, 31'd0, 1'b0, 31'd0, 1'b1, KIND_ADDED, 31'd1);
        add_row(FUNC_ADD, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 31'd0, 1'b1, KIND_ADDED, 31'd2);
        // one-shot fires at zero elapsed; periodic fires exactly at its delay across the wrap
        add_row(FUNC_TICK, 32'd0, 31'd0, 1'b0, 31'd0, 1'b0, KIND_DONE, 31'd0);
        add_row(FUNC_TICK, 32'h7FFF_FFFE, 31'd0, 1'b0, 31'd0, 1'b0, KIND_DONE, 31'd0);
        // fill the bank, then one add too many
        for (int i = 0; i < SLOTS - 1; i++)
            add_row(FUNC_ADD, 32'h8000_0000 + i, 31'(3 * i), 1'(i), 31'd0, 1'b1,
                    KIND_ADDED, 31'(3 + i));
        add_row(FUNC_ADD, 32'h8000_0100, 31'd5, 1'b0, 31'd0, 1'b1, KIND_FULL, 31'd0);
        // every timer expires at once: largest burst of fired beats
        add_row(FUNC_TICK, 32'hFFFF_FFFD, 31'd0, 1'b0, 31'd0, 1'b0, KIND_DONE, 31'd0);
        // the oldest periodic timer, then the same id again
        add_row(FUNC_REMOVE, 32'd0, 31'd0, 1'b0, 31'd2, 1'b1, KIND_REMOVED, 31'd2);
        add_row(FUNC_REMOVE, 32'd0, 31'd0, 1'b0, 31'd2, 1'b1, KIND_NOT_FOUND, 31'd0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r])
            drive_command(directed_rows[r].cmd, directed_rows[r].typed, directed_rows[r].want);
        drain_results();

        // random part, alternating fill and churn phases
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            c = random_command(((done_items / 25) % 2) == 1);
            drive_command(c, 1'b0, '0);
            if (c.func != FUNC_UNUSED) begin
                done_items++;
                if (done_items % 50 == 0) drain_results();
            end
        end
        s_tvalid <= 1'b0;

        // let the last command finish, then watch for stray beats
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/stb_pkg.sv
hdl/stb_cell.sv
hdl/stb_chain.sv
hdl/software_timer_bank_top.sv
verif/testbench.sv
